// ===== hdl/bta_pkg.sv =====
// shared types, constants and command codes of the buddy tree allocator
// no dependencies; imported by bta_dp, bta_ctrl and buddy_tree_allocator
`default_nettype none

package bta_pkg;

  // tree depth default and fixed field widths
  localparam int unsigned DefLayers = 10;
  localparam int unsigned SizeW     = 40;
  localparam int unsigned ByteW     = 41;
  localparam int unsigned CfgW      = 6;
  localparam int unsigned StW       = 2;
  localparam int unsigned HdrBytes  = 4;

  localparam logic [CfgW-1:0] DefStoreLog2 = 6'd24;

  // result status codes
  localparam logic [StW-1:0] ST_DONE   = 2'd0;
  localparam logic [StW-1:0] ST_NOMEM  = 2'd1;
  localparam logic [StW-1:0] ST_TOOBIG = 2'd2;

  // datapath operation codes
  localparam int unsigned OpW = 4;
  localparam logic [OpW-1:0] OP_NONE  = 4'd0;
  localparam logic [OpW-1:0] OP_CLR   = 4'd1;
  localparam logic [OpW-1:0] OP_LOAD  = 4'd2;
  localparam logic [OpW-1:0] OP_DEC   = 4'd3;
  localparam logic [OpW-1:0] OP_KEY   = 4'd4;
  localparam logic [OpW-1:0] OP_SRD   = 4'd5;
  localparam logic [OpW-1:0] OP_SNXT  = 4'd6;
  localparam logic [OpW-1:0] OP_OOM   = 4'd7;
  localparam logic [OpW-1:0] OP_MINIT = 4'd8;
  localparam logic [OpW-1:0] OP_MSTEP = 4'd9;
  localparam logic [OpW-1:0] OP_AINIT = 4'd10;
  localparam logic [OpW-1:0] OP_AUP   = 4'd11;
  localparam logic [OpW-1:0] OP_FRD   = 4'd12;
  localparam logic [OpW-1:0] OP_FUP   = 4'd13;
  localparam logic [OpW-1:0] OP_OUT   = 4'd14;

  // controller to datapath
  typedef struct packed {
    logic [OpW-1:0] op;
    logic           wval;
  } bta_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic too_large;
    logic is_free;
    logic rd_used;
    logic k_last;
    logic mark_done;
    logic cl_zero;
    logic clr_last;
    logic out_busy;
  } bta_sts_t;

endpackage

`default_nettype wire

// ===== hdl/bta_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module bta_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hdl/bta_dp.sv =====
// allocator datapath: request registers, tree walk counters, used-bit ram, result register
// depends on bta_pkg and bta_ram
`default_nettype none

module bta_dp import bta_pkg::*; #(
  parameter int unsigned LAYERS = DefLayers
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CfgW-1:0]   cfg_wdata_i,
  input  wire logic              req_free_i,
  input  wire logic [SizeW-1:0]  payload_i,
  input  wire logic [SizeW-1:0]  offset_i,
  input  wire bta_cmd_t          cmd_i,
  output bta_sts_t               sts_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [StW-1:0]         out_status_o,
  output logic [SizeW-1:0]       out_offset_o,
  output logic [ByteW-1:0]       out_bytes_o
);

  localparam int unsigned AW = LAYERS + 1;
  localparam int unsigned LW = $clog2(LAYERS + 1);
  localparam int unsigned KW = LAYERS;

  logic [CfgW-1:0]  slog_q;
  logic             free_q;
  logic [ByteW-1:0] need_q;
  logic [SizeW-1:0] off_q;
  logic [CfgW-1:0]  blog_q;
  logic             too_large_q;
  logic             oom_q;
  logic [LW-1:0]    lay_q;
  logic [KW-1:0]    k_q;
  logic [LW-1:0]    cl_q;
  logic [AW-1:0]    x_q, lo_q, hi_q;
  logic [KW-1:0]    idx_q;
  logic [AW-1:0]    clr_q;
  logic             out_valid_q;
  logic [StW-1:0]   out_status_q;
  logic [SizeW-1:0] out_offset_q;
  logic [ByteW-1:0] out_bytes_q;

  logic [CfgW-1:0]  nbits, min_log, blog_c;
  logic [AW-1:0]    lay_mask;
  logic [SizeW-1:0] off_shift;
  logic             ram_we, ram_wdata, ram_rdata;
  logic [AW-1:0]    ram_waddr, ram_raddr;

  // flat index of the first node of a layer
  function automatic logic [AW-1:0] layer_base(input logic [LW-1:0] cl);
    layer_base = (AW'(1) << cl) - AW'(1);
  endfunction

  // store size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slog_q <= DefStoreLog2;
    end else if (cfg_we_i) begin
      slog_q <= cfg_wdata_i;
    end
  end

  // block size decode: bit length of payload plus header, clamped to the smallest block
  always_comb begin
    nbits = '0;
    for (int i = 0; i < ByteW; i++) begin
      if (need_q[i]) nbits = CfgW'(i + 1);
    end
    min_log = (slog_q >= CfgW'(LAYERS)) ? slog_q - CfgW'(LAYERS) : '0;
    blog_c  = (nbits < min_log) ? min_log : nbits;
  end

  assign lay_mask  = (AW'(1) << lay_q) - AW'(1);
  assign off_shift = off_q >> blog_q;

  // tree walk registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        free_q <= req_free_i;
        need_q <= {1'b0, payload_i} + ByteW'(HdrBytes);
        off_q  <= offset_i;
        oom_q  <= 1'b0;
      end
      OP_DEC: begin
        blog_q      <= blog_c;
        too_large_q <= blog_c > slog_q;
        lay_q       <= LW'(slog_q - blog_c);
      end
      OP_KEY: begin
        k_q <= free_q ? off_shift[KW-1:0] & lay_mask[KW-1:0] : '0;
      end
      OP_SNXT: k_q <= k_q + KW'(1);
      OP_OOM:  oom_q <= 1'b1;
      OP_MINIT: begin
        cl_q <= lay_q;
        x_q  <= {1'b0, k_q};
        lo_q <= {1'b0, k_q};
        hi_q <= {1'b0, k_q} + AW'(1);
      end
      OP_MSTEP: begin
        if (x_q + AW'(1) == hi_q) begin
          if (cl_q != LW'(LAYERS)) begin
            cl_q <= cl_q + LW'(1);
            x_q  <= lo_q << 1;
            lo_q <= lo_q << 1;
            hi_q <= hi_q << 1;
          end
        end else begin
          x_q <= x_q + AW'(1);
        end
      end
      OP_AINIT: begin
        cl_q  <= lay_q;
        idx_q <= k_q;
      end
      OP_AUP, OP_FUP: begin
        cl_q  <= cl_q - LW'(1);
        idx_q <= idx_q >> 1;
      end
      default: ;
    endcase
  end

  // clearing pass counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.op == OP_CLR) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  // ram port control
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = 1'b0;
    ram_waddr = '0;
    ram_raddr = '0;
    case (cmd_i.op)
      OP_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
      end
      OP_SRD: ram_raddr = layer_base(lay_q) + {1'b0, k_q};
      OP_MSTEP: begin
        ram_we    = 1'b1;
        ram_wdata = cmd_i.wval;
        ram_waddr = layer_base(cl_q) + x_q;
      end
      OP_AUP: begin
        ram_we    = 1'b1;
        ram_wdata = 1'b1;
        ram_waddr = layer_base(cl_q - LW'(1)) + {1'b0, idx_q >> 1};
      end
      OP_FRD: ram_raddr = layer_base(cl_q) + {1'b0, idx_q ^ KW'(1)};
      OP_FUP: begin
        ram_we    = 1'b1;
        ram_waddr = layer_base(cl_q - LW'(1)) + {1'b0, idx_q >> 1};
      end
      default: ;
    endcase
  end

  bta_ram #(
    .Width (1),
    .Depth (2 ** AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_OUT) begin
      out_status_q <= too_large_q ? ST_TOOBIG : (oom_q ? ST_NOMEM : ST_DONE);
      out_offset_q <= (too_large_q || oom_q || free_q) ? '0 : SizeW'(k_q) << blog_q;
      out_bytes_q  <= too_large_q ? '0 : ByteW'(1) << blog_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_offset_o = out_offset_q;
  assign out_bytes_o  = out_bytes_q;

  // status to controller
  assign sts_o.too_large = too_large_q;
  assign sts_o.is_free   = free_q;
  assign sts_o.rd_used   = ram_rdata;
  assign sts_o.k_last    = {1'b0, k_q} == lay_mask;
  assign sts_o.mark_done = (x_q + AW'(1) == hi_q) && (cl_q == LW'(LAYERS));
  assign sts_o.cl_zero   = cl_q == '0;
  assign sts_o.clr_last  = clr_q == AW'((2 ** AW) - 2);
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

  // checks
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_OUT |-> !(out_valid_q && !out_ready_i))
    else $error("result loaded over a held result");
  a_mark_layer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_MSTEP |-> cl_q <= LW'(LAYERS) && x_q < hi_q)
    else $error("subtree mark out of range");
  a_up_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_AUP || cmd_i.op == OP_FUP) |-> cl_q != '0)
    else $error("ancestor step above root");
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_SRD |-> {1'b0, k_q} <= lay_mask)
    else $error("scan past end of layer");

endmodule

`default_nettype wire

// ===== hdl/bta_ctrl.sv =====
// allocator controller state machine: sequences clear, scan, mark and ancestor walks
// depends on bta_pkg
`default_nettype none

module bta_ctrl import bta_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire bta_sts_t sts_i,
  output bta_cmd_t      cmd_o
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_CHK   = 4'd3;
  localparam logic [3:0] S_SRD   = 4'd4;
  localparam logic [3:0] S_SCHK  = 4'd5;
  localparam logic [3:0] S_MINIT = 4'd6;
  localparam logic [3:0] S_MARK  = 4'd7;
  localparam logic [3:0] S_AINIT = 4'd8;
  localparam logic [3:0] S_AUP   = 4'd9;
  localparam logic [3:0] S_FRD   = 4'd10;
  localparam logic [3:0] S_FCHK  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and command
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    cmd_o.wval = !sts_i.is_free;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLR: begin
        cmd_o.op = OP_CLR;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DEC;
        end
      end
      S_DEC: begin
        cmd_o.op = OP_DEC;
        state_d  = S_CHK;
      end
      S_CHK: begin
        cmd_o.op = OP_KEY;
        if (sts_i.too_large)    state_d = S_DONE;
        else if (sts_i.is_free) state_d = S_MINIT;
        else                    state_d = S_SRD;
      end
      S_SRD: begin
        cmd_o.op = OP_SRD;
        state_d  = S_SCHK;
      end
      S_SCHK: begin
        if (!sts_i.rd_used) begin
          state_d = S_MINIT;
        end else if (sts_i.k_last) begin
          cmd_o.op = OP_OOM;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = OP_SNXT;
          state_d  = S_SRD;
        end
      end
      S_MINIT: begin
        cmd_o.op = OP_MINIT;
        state_d  = S_MARK;
      end
      S_MARK: begin
        cmd_o.op = OP_MSTEP;
        if (sts_i.mark_done) state_d = S_AINIT;
      end
      S_AINIT: begin
        cmd_o.op = OP_AINIT;
        state_d  = sts_i.is_free ? S_FRD : S_AUP;
      end
      S_AUP: begin
        if (sts_i.cl_zero) state_d = S_DONE;
        else               cmd_o.op = OP_AUP;
      end
      S_FRD: begin
        if (sts_i.cl_zero) begin
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_FRD;
          state_d  = S_FCHK;
        end
      end
      S_FCHK: begin
        if (sts_i.rd_used) begin
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_FUP;
          state_d  = S_FRD;
        end
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.op = OP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_CLR;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/buddy_tree_allocator.sv =====
// Buddy allocator over a binary tree of used bits kept in a one-bit ram of
// 2^(LAYERS+1) entries. After reset a clearing pass writes every node free,
// and no request is taken until it ends. Each request is handled alone. A
// request is accepted, decoded and checked, and its result is registered at
// the end. An allocate adds a read and a check per node scanned at the target
// layer, a setup for the mark, a write per node of the subtree, a setup for
// the ancestor walk and a write per ancestor. A free adds the same setups and
// subtree writes, then a buddy read and a parent clear per ancestor cleared,
// and stops at the root or at a used buddy. A request too large for the store
// goes straight to its result; an allocate that finds no free node scans every
// node of its layer first. The result cycle waits while a held result is not
// taken. The next request is taken while a result waits in the output register.
// depends on bta_pkg, bta_ctrl, bta_dp
`default_nettype none

module buddy_tree_allocator import bta_pkg::*; #(
  parameter int unsigned LAYERS = DefLayers
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CfgW-1:0]   cfg_wdata_i,   // store_size_log2
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [79:0]       s_axis_tdata,  // payload_bytes[39:0], offset_bytes[79:40]
  input  wire logic              s_axis_tuser,  // req_type
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [87:0]            m_axis_tdata,  // block_offset[39:0], block_bytes[80:40], zero
  output logic [StW-1:0]         m_axis_tuser   // status
);

  bta_cmd_t         cmd;
  bta_sts_t         sts;
  logic [SizeW-1:0] out_offset;
  logic [ByteW-1:0] out_bytes;

  bta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bta_dp #(
    .LAYERS (LAYERS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_free_i   (s_axis_tuser),
    .payload_i    (s_axis_tdata[39:0]),
    .offset_i     (s_axis_tdata[79:40]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (m_axis_tuser),
    .out_offset_o (out_offset),
    .out_bytes_o  (out_bytes)
  );

  // result beat packing
  assign m_axis_tdata = {7'd0, out_bytes, out_offset};

endmodule

`default_nettype wire

// ===== sim/tb_buddy_tree_allocator.sv =====
// self-checking testbench for the buddy tree allocator: streams allocate and free
// requests, predicts every result from a local copy of the used-bit tree
// depends on bta_pkg and the buddy_tree_allocator rtl
`timescale 1ns / 1ps

module tb_buddy_tree_allocator;
  import bta_pkg::*;

  localparam int unsigned Layers    = DefLayers;
  localparam int unsigned NodeCnt   = (1 << (Layers + 1)) - 1;
  localparam longint unsigned CycLimit = 40_000_000;

  typedef enum bit {REQ_ALLOC = 1'b0, REQ_FREE = 1'b1} req_kind_e;

  typedef struct {
    logic [StW-1:0]   status;
    logic [SizeW-1:0] blk_off;
    logic [ByteW-1:0] blk_bytes;
  } alloc_res_t;

  // tree model and queue of results still to come
  class alloc_scoreboard;
    bit               used[NodeCnt];
    int unsigned      store_log2;
    alloc_res_t       pending_q[$];
    int unsigned      mismatches;

    function new();
      store_log2 = 32'(DefStoreLog2);
      mismatches = 0;
    endfunction

    function void fill_subtree(int unsigned lay, int unsigned k, bit val);
      for (int unsigned d = 0; lay + d <= Layers; d++) begin
        for (int unsigned x = k << d; x < ((k + 1) << d); x++) begin
          used[(1 << (lay + d)) - 1 + x] = val;
        end
      end
    endfunction

    // work out the result of one accepted request and update the tree
    function alloc_res_t note_request(req_kind_e kind, logic [SizeW-1:0] pay,
                                      logic [SizeW-1:0] off);
      alloc_res_t r;
      int unsigned s, min_log, blog, lay, cnt, k;
      logic [ByteW-1:0] need;
      logic [63:0] wide;
      s = store_log2;
      min_log = (s >= Layers) ? s - Layers : 0;
      need = {1'b0, pay} + ByteW'(HdrBytes);
      blog = 0;
      for (int unsigned b = 0; b < ByteW; b++) if (need[b]) blog = b + 1;
      if (blog < min_log) blog = min_log;
      r.status = ST_DONE;
      r.blk_off = '0;
      r.blk_bytes = '0;
      if (blog > s) begin
        r.status = ST_TOOBIG;
      end else begin
        lay = s - blog;
        wide = 64'd1 << blog;
        r.blk_bytes = wide[ByteW-1:0];
        cnt = 1 << lay;
        if (kind == REQ_ALLOC) begin
          k = 0;
          while (k < cnt && used[cnt - 1 + k]) k++;
          if (k == cnt) begin
            r.status = ST_NOMEM;
          end else begin
            fill_subtree(lay, k, 1'b1);
            for (int unsigned j = 1; j <= lay; j++) used[(1 << (lay - j)) - 1 + (k >> j)] = 1'b1;
            wide = 64'(k) << blog;
            r.blk_off = wide[SizeW-1:0];
          end
        end else begin
          wide = 64'(off) >> blog;
          k = wide[31:0] & (cnt - 1);
          fill_subtree(lay, k, 1'b0);
          for (int unsigned j = 0; j < lay; j++) begin
            if (used[(1 << (lay - j)) - 1 + ((k >> j) ^ 1)]) break;
            used[(1 << (lay - j - 1)) - 1 + (k >> (j + 1))] = 1'b0;
          end
        end
      end
      pending_q.push_back(r);
      return r;
    endfunction

    // compare one result beat with the oldest prediction
    function void check_result(alloc_res_t got);
      alloc_res_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: st=%0d off=%h bytes=%h",
                   got.status, got.blk_off, got.blk_bytes);
        return;
      end
      want = pending_q.pop_front();
      if (got.status !== want.status || got.blk_off !== want.blk_off ||
          got.blk_bytes !== want.blk_bytes) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp st=%0d off=%h bytes=%h, got st=%0d off=%h bytes=%h",
                   want.status, want.blk_off, want.blk_bytes,
                   got.status, got.blk_off, got.blk_bytes);
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CfgW-1:0]   cfg_wdata_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [79:0]       s_axis_tdata = '0;
  logic              s_axis_tuser = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [87:0]       m_axis_tdata;
  logic [StW-1:0]    m_axis_tuser;

  buddy_tree_allocator #(.LAYERS(Layers)) i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  alloc_scoreboard sb = new();
  longint unsigned cycles = 0;
  int              burst_left = 0;
  logic [SizeW-1:0] live_off[$];
  logic [SizeW-1:0] live_pay[$];

  always #1 clk_i = ~clk_i;

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycLimit) begin
      $display("[buddy_tree_allocator] ERROR");
      $finish;
    end
  end

  // result side: check beats, stall in changing modes
  int unsigned stall_mode = 0;
  always @(posedge clk_i) begin
    alloc_res_t got;
    if (m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tuser;
      got.blk_off = m_axis_tdata[39:0];
      got.blk_bytes = m_axis_tdata[80:40];
      sb.check_result(got);
    end
    if (cycles % 300 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 9) < 7);
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic logic [SizeW-1:0] rand40();
    return {8'($urandom_range(0, 255)), $urandom};
  endfunction

  // payload whose block lands on the given layer
  function automatic logic [SizeW-1:0] payload_for(int unsigned lay);
    longint unsigned blog, lo, hi;
    blog = sb.store_log2 - lay;
    hi = (64'd1 << blog) - 1;
    lo = (lay == Layers) ? 4 : (64'd1 << (blog - 1));
    // smallest block below the header size: fall back to an empty payload
    if (hi < lo) hi = lo;
    return SizeW'(lo + ({$urandom, $urandom} % (hi - lo + 1)) - 4);
  endfunction

  // one request beat, sent in bursts with random gaps
  task automatic send_req(req_kind_e kind, logic [SizeW-1:0] pay, logic [SizeW-1:0] off);
    alloc_res_t r;
    s_axis_tdata <= {off, pay};
    s_axis_tuser <= kind;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    r = sb.note_request(kind, pay, off);
    if (kind == REQ_ALLOC && r.status == ST_DONE) begin
      live_off.push_back(r.blk_off);
      live_pay.push_back(pay);
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 12);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(20, 200) : $urandom_range(1, 6))
        @(posedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_store_log2(int unsigned v);
    cfg_wdata_i <= CfgW'(v);
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.store_log2 = v;
  endtask

  task automatic free_live(int unsigned idx);
    logic [SizeW-1:0] o, p;
    o = live_off[idx];
    p = live_pay[idx];
    live_off.delete(idx);
    live_pay.delete(idx);
    send_req(REQ_FREE, p, o);
  endtask

  int unsigned phase_log2[6] = '{24, 12, 40, 17, 33, 0};

  initial begin
    int unsigned r, lay;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_store_log2(24);

    // directed: extremes, whole store, out of memory, odd frees
    send_req(REQ_ALLOC, '0, '0);
    send_req(REQ_ALLOC, '1, '0);
    send_req(REQ_FREE, '1, '1);
    send_req(REQ_ALLOC, payload_for(0), '0);
    send_req(REQ_ALLOC, '0, '0);
    send_req(REQ_FREE, payload_for(0), '0);
    send_req(REQ_ALLOC, payload_for(1), '0);
    send_req(REQ_ALLOC, payload_for(1), '0);
    send_req(REQ_ALLOC, payload_for(1), '0);
    send_req(REQ_FREE, payload_for(1), 40'h80_0000);
    send_req(REQ_FREE, '0, '1);
    send_req(REQ_FREE, payload_for(5), 40'hAA_AAAA_AAAA);
    send_req(REQ_FREE, payload_for(1), '0);
    send_req(REQ_ALLOC, payload_for(10), '0);
    send_req(REQ_ALLOC, 40'h7F_FFFF_FFFB, '0);
    live_off.delete();
    live_pay.delete();
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      set_store_log2(phase_log2[ph] != 0 ? phase_log2[ph] : $urandom_range(12, 40));
      for (int n = 0; n < 280; n++) begin
        r = $urandom_range(0, 99);
        if (n == 140) drain();
        if (live_off.size() != 0 && r < 40) begin
          free_live($urandom_range(0, live_off.size() - 1));
        end else if (r < 85) begin
          lay = ($urandom_range(0, 3) == 0) ? $urandom_range(0, Layers) :
                $urandom_range(6, Layers);
          send_req(REQ_ALLOC, payload_for(lay), rand40());
        end else if (r < 93) begin
          send_req(REQ_FREE, payload_for($urandom_range(0, Layers)), rand40());
        end else begin
          send_req(req_kind_e'($urandom_range(0, 1)), rand40(), rand40());
        end
      end
      // release what is still held before the next store size
      while (live_off.size() != 0) free_live(0);
      drain();
    end

    repeat (100) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("[buddy_tree_allocator] OK");
    end else begin
      $display("[buddy_tree_allocator] ERROR");
    end
    $finish;
  end

endmodule
